### design/bbn_pkg.sv
// Shared types and constants of the 3x3 edge-normalized box blur.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package bbn_pkg;

  // Frame geometry
  localparam int MAX_COLS   = 128;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = 12;
  localparam int PIX_W      = 8;
  localparam int CFG_COLS_W = 8;
  localparam int CFG_ROWS_W = 13;
  localparam int MIN_COLS   = 2;
  localparam int MIN_ROWS   = 2;
  localparam int MAX_ROWS   = 4096;
  localparam int RESET_COLS = 100;
  localparam int RESET_ROWS = 100;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic {
    REG_FRAME_COLS,
    REG_FRAME_ROWS
  } reg_idx_e;

  // Queues between the parts
  localparam int JOB_DEPTH = 4;
  localparam int RES_DEPTH = 4;
  localparam int Q_PTR_W   = $clog2(JOB_DEPTH);
  localparam int Q_CNT_W   = Q_PTR_W + 1;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = RES_PTR_W + 1;

  // Arithmetic of the mean: 9 pixels of 8 bits, divide by reciprocal
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;
  localparam logic [RECIP_W-1:0] RECIP_3 = 15'd21846;

  // Result kinds of one input pixel, in emission order
  localparam int KIND_N = 4;
  typedef enum logic [1:0] {
    KIND_PREV_MID,   // row r-1, column c-1
    KIND_PREV_EDGE,  // row r-1, last column
    KIND_LAST_MID,   // last row, column c-1
    KIND_LAST_EDGE   // last row, last column
  } kind_e;

  typedef enum logic [1:0] {
    DIV_BY_9,
    DIV_BY_6,
    DIV_BY_4
  } div_e;

  typedef struct packed {
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    logic             restart;
  } cfg_t;

  // Window rows: 0 = two rows up, 1 = one row up, 2 = current row
  // Window columns: 0 = c-2, 1 = c-1, 2 = c
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    win_t              win;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [KIND_N-1:0] kinds;
    logic              top_ok;
    logic              left_ok;
  } job_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_of_burst;
    logic             last_of_frame;
  } res_t;

endpackage

`default_nettype wire

### design/box_blur_3x3_edge_normalized.sv
// Top level of the streaming 3x3 box blur with edge normalization.
// Depends on bbn_pkg, bbn_regs, bbn_front, bbn_job_q and bbn_back.
//
// Pixels enter in raster order through a push/full queue port, one per clock
// while full is low. Each result is the truncated mean of the in-image 3x3
// neighbors of a pixel (9 inside, 6 on an edge, 4 at a corner) and leaves
// through an empty/pop queue port, tagged with its row and column. Results lag
// the input by one row and one column; the first row gives no results, and on
// the last row every pixel also flushes that row, so a pixel releases up to
// four results (one burst, last_of_burst on its final result; last_of_frame on
// the bottom-right pixel). The input side takes one pixel per clock while full
// is low; the output side delivers one result per clock while pop is held
// high, and the four-entry job and result queues absorb a burst of two to four
// results; on the last row, where most pixels release two results, full holds
// off the input as the job queue fills. A pixel's first result is registered
// in turn in the line buffer read, the job queue, the sum register and, after
// the divide, the result queue. The line buffer is one 128 x 16-bit memory
// read and written once per pixel; it needs no clearing. Registers: frame_cols
// at byte address 0, frame_rows at byte address 4; values out of range
// saturate (columns 2..128, rows 2..4096), and a write restarts the frame at
// row 0, column 0. Write them only while idle.
`default_nettype none

module box_blur_3x3_edge_normalized (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [bbn_pkg::PIX_W-1:0]   pixel_in_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic      [bbn_pkg::PIX_W-1:0]   pixel_out_o,
  output logic      [bbn_pkg::ROW_W-1:0]   out_row_o,
  output logic      [bbn_pkg::COL_W-1:0]   out_col_o,
  output logic                             last_of_burst_o,
  output logic                             last_of_frame_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bbn_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bbn_pkg::DATA_W-1:0]  pwdata,
  output logic      [bbn_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import bbn_pkg::*;

  cfg_t                cfg;
  logic                jq_push, jq_pop, jq_valid;
  job_t                jq_in, jq_head;
  logic [Q_CNT_W-1:0]  jq_count;

  bbn_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .pixel_in_i (pixel_in_i),
    .cfg_i      (cfg),
    .jq_count_i (jq_count),
    .jq_push_o  (jq_push),
    .jq_job_o   (jq_in)
  );

  bbn_job_q u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .job_i   (jq_in),
    .pop_i   (jq_pop),
    .valid_o (jq_valid),
    .job_o   (jq_head),
    .count_o (jq_count)
  );

  bbn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .jq_valid_i      (jq_valid),
    .jq_job_i        (jq_head),
    .jq_pop_o        (jq_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .pixel_out_o     (pixel_out_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_burst_o (last_of_burst_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire

### design/bbn_regs.sv
// Configuration registers (frame columns and rows) behind an APB-style port.
// Depends on bbn_pkg; hands the saturated geometry to the front end as cfg_t.
`default_nettype none

module bbn_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bbn_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bbn_pkg::DATA_W-1:0]   pwdata,
  output logic      [bbn_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output bbn_pkg::cfg_t                     cfg_o
);
  import bbn_pkg::*;

  logic [CFG_COLS_W-1:0] cols_q, cols_d, cols_eff, cols_m1;
  logic [CFG_ROWS_W-1:0] rows_q, rows_d, rows_eff, rows_m1;
  logic                  wr_en;
  reg_idx_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1]);

  // Decode the write
  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_COLS: cols_d = pwdata[CFG_COLS_W-1:0];
        REG_FRAME_ROWS: rows_d = pwdata[CFG_ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= CFG_COLS_W'(RESET_COLS);
      rows_q <= CFG_ROWS_W'(RESET_ROWS);
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  // Read back the raw values
  always_comb begin
    unique case (idx)
      REG_FRAME_COLS: prdata = DATA_W'(cols_q);
      REG_FRAME_ROWS: prdata = DATA_W'(rows_q);
      default:        prdata = '0;
    endcase
  end

  // Saturate the geometry to the supported range
  always_comb begin
    if (cols_q < CFG_COLS_W'(MIN_COLS))      cols_eff = CFG_COLS_W'(MIN_COLS);
    else if (cols_q > CFG_COLS_W'(MAX_COLS)) cols_eff = CFG_COLS_W'(MAX_COLS);
    else                                     cols_eff = cols_q;
    if (rows_q < CFG_ROWS_W'(MIN_ROWS))      rows_eff = CFG_ROWS_W'(MIN_ROWS);
    else if (rows_q > CFG_ROWS_W'(MAX_ROWS)) rows_eff = CFG_ROWS_W'(MAX_ROWS);
    else                                     rows_eff = rows_q;
  end

  assign cols_m1 = cols_eff - CFG_COLS_W'(1);
  assign rows_m1 = rows_eff - CFG_ROWS_W'(1);

  assign cfg_o.last_col = cols_m1[COL_W-1:0];
  assign cfg_o.last_row = rows_m1[ROW_W-1:0];
  // A write restarts the frame
  assign cfg_o.restart  = wr_en;

endmodule

`default_nettype wire

### design/bbn_front.sv
// Front end: takes pixels, tracks row and column, runs the line buffer and
// the 3x3 window, and classifies which results each pixel releases. Uses bbn_pkg.
`default_nettype none

module bbn_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [bbn_pkg::PIX_W-1:0]     pixel_in_i,
  input  wire bbn_pkg::cfg_t                 cfg_i,
  input  wire logic [bbn_pkg::Q_CNT_W-1:0]   jq_count_i,
  output logic                               jq_push_o,
  output bbn_pkg::job_t                      jq_job_o
);
  import bbn_pkg::*;

  logic                  accept;
  logic [Q_CNT_W:0]      used;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      col_q, col_d;

  // Line buffer: upper byte holds row r-2, lower byte row r-1
  logic [2*PIX_W-1:0]    line_mem [MAX_COLS];
  logic [2*PIX_W-1:0]    line_rd_q;

  logic                  f1_valid_q;
  logic [PIX_W-1:0]      f1_pix_q;
  logic [ROW_W-1:0]      f1_row_q;
  logic [COL_W-1:0]      f1_col_q;
  logic                  f1_last_row_q;
  logic                  f1_last_col_q;

  win_t                  win_q, win_d;
  logic                  has_prev, has_left;
  logic [KIND_N-1:0]     kinds;

  // Hold off input while the job queue may run out of room
  assign used   = {1'b0, jq_count_i} + {{Q_CNT_W{1'b0}}, f1_valid_q};
  assign full_o = used >= (Q_CNT_W+1)'(JOB_DEPTH);
  assign accept = push_i & ~full_o;

  // Advance the raster position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_i.restart) begin
      row_d = '0;
      col_d = '0;
    end else if (accept) begin
      if (col_q == cfg_i.last_col) begin
        col_d = '0;
        row_d = (row_q == cfg_i.last_row) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      f1_valid_q <= 1'b0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      f1_valid_q <= accept;
    end
  end

  // Capture the pixel and its position for the window stage
  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_pix_q      <= pixel_in_i;
      f1_row_q      <= row_q;
      f1_col_q      <= col_q;
      f1_last_row_q <= (row_q == cfg_i.last_row);
      f1_last_col_q <= (col_q == cfg_i.last_col);
    end
  end

  // Read the column on accept, write it back in the next cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_rd_q <= line_mem[col_q];
    end
    if (f1_valid_q) begin
      line_mem[f1_col_q] <= {line_rd_q[PIX_W-1:0], f1_pix_q};
    end
  end

  // Shift the window one column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = line_rd_q[2*PIX_W-1:PIX_W];
    win_d[1][2] = line_rd_q[PIX_W-1:0];
    win_d[2][2] = f1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (f1_valid_q) begin
      win_q <= win_d;
    end
  end

  // Classify the results this pixel releases
  assign has_prev = (f1_row_q != '0);
  assign has_left = (f1_col_q != '0);

  always_comb begin
    kinds                 = '0;
    kinds[KIND_PREV_MID]  = has_prev & has_left;
    kinds[KIND_PREV_EDGE] = has_prev & f1_last_col_q;
    kinds[KIND_LAST_MID]  = has_prev & f1_last_row_q & has_left;
    kinds[KIND_LAST_EDGE] = has_prev & f1_last_row_q & f1_last_col_q;
  end

  // Queue only pixels that release something
  assign jq_push_o        = f1_valid_q & (kinds != '0);
  assign jq_job_o.win     = win_d;
  assign jq_job_o.row     = f1_row_q;
  assign jq_job_o.col     = f1_col_q;
  assign jq_job_o.kinds   = kinds;
  assign jq_job_o.top_ok  = (f1_row_q > ROW_W'(1));
  assign jq_job_o.left_ok = (f1_col_q > COL_W'(1));

endmodule

`default_nettype wire

### design/bbn_job_q.sv
// Short job queue between the front end and the back end of the box blur.
// Uses bbn_pkg for the job type and depth.
`default_nettype none

module bbn_job_q (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  input  wire bbn_pkg::job_t                 job_i,
  input  wire logic                          pop_i,
  output logic                               valid_o,
  output bbn_pkg::job_t                      job_o,
  output logic      [bbn_pkg::Q_CNT_W-1:0]   count_o
);
  import bbn_pkg::*;

  job_t                 mem_q [JOB_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0]   cnt_q;

  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_ptr_q];
  assign count_o = cnt_q;

  // Store the job
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      cnt_q <= cnt_q + Q_CNT_W'(push_i) - Q_CNT_W'(pop_i);
    end
  end

endmodule

`default_nettype wire

### design/bbn_back.sv
// Back end: expands each job into its results, sums the in-image neighbors,
// divides by 9, 6 or 4 and queues the results. Uses bbn_pkg.
`default_nettype none

module bbn_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          jq_valid_i,
  input  wire bbn_pkg::job_t                 jq_job_i,
  output logic                               jq_pop_o,
  input  wire logic                          pop_i,
  output logic                               empty_o,
  output logic      [bbn_pkg::PIX_W-1:0]     pixel_out_o,
  output logic      [bbn_pkg::ROW_W-1:0]     out_row_o,
  output logic      [bbn_pkg::COL_W-1:0]     out_col_o,
  output logic                               last_of_burst_o,
  output logic                               last_of_frame_o
);
  import bbn_pkg::*;

  logic [KIND_N-1:0]  done_q;
  logic [KIND_N-1:0]  pending, sel_mask;
  kind_e              sel_kind;
  logic               sel_last;
  logic               issue, credit_ok;
  logic [2:0]         row_mask, col_mask;
  logic [ROW_W-1:0]   orow;
  logic [COL_W-1:0]   ocol;
  logic               lof;
  div_e               div_sel;
  logic [SUM_W-1:0]   sum;

  logic               s1_valid_q;
  logic [SUM_W-1:0]   s1_sum_q;
  div_e               s1_div_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [COL_W-1:0]   s1_col_q;
  logic               s1_lob_q;
  logic               s1_lof_q;

  logic [SUM_W-1:0]   mul_a;
  logic [RECIP_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PIX_W-1:0]   quot;
  res_t               res_wr;

  res_t                 res_mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_ptr_q, res_rd_ptr_q;
  logic [RES_CNT_W-1:0] res_cnt_q;
  logic                 res_pop;

  // Pick the next result of the head job, in emission order
  assign pending = jq_job_i.kinds & ~done_q;

  always_comb begin
    if (pending[KIND_PREV_MID])       sel_kind = KIND_PREV_MID;
    else if (pending[KIND_PREV_EDGE]) sel_kind = KIND_PREV_EDGE;
    else if (pending[KIND_LAST_MID])  sel_kind = KIND_LAST_MID;
    else                              sel_kind = KIND_LAST_EDGE;
  end

  assign sel_mask = KIND_N'(1) << sel_kind;
  assign sel_last = ((pending & ~sel_mask) == '0);

  // Issue only when the result queue surely has room
  assign credit_ok = ({1'b0, res_cnt_q} + {{RES_CNT_W{1'b0}}, s1_valid_q})
                     < (RES_CNT_W+1)'(RES_DEPTH);
  assign issue     = jq_valid_i & credit_ok;
  assign jq_pop_o  = issue & sel_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else if (issue) begin
      done_q <= sel_last ? '0 : (done_q | sel_mask);
    end
  end

  // Decode the neighborhood of the selected result
  always_comb begin
    unique case (sel_kind)
      KIND_PREV_MID: begin
        row_mask = {2'b11, jq_job_i.top_ok};
        col_mask = {2'b11, jq_job_i.left_ok};
        orow     = jq_job_i.row - ROW_W'(1);
        ocol     = jq_job_i.col - COL_W'(1);
        lof      = 1'b0;
      end
      KIND_PREV_EDGE: begin
        row_mask = {2'b11, jq_job_i.top_ok};
        col_mask = 3'b110;
        orow     = jq_job_i.row - ROW_W'(1);
        ocol     = jq_job_i.col;
        lof      = 1'b0;
      end
      KIND_LAST_MID: begin
        row_mask = 3'b110;
        col_mask = {2'b11, jq_job_i.left_ok};
        orow     = jq_job_i.row;
        ocol     = jq_job_i.col - COL_W'(1);
        lof      = 1'b0;
      end
      default: begin
        row_mask = 3'b110;
        col_mask = 3'b110;
        orow     = jq_job_i.row;
        ocol     = jq_job_i.col;
        lof      = 1'b1;
      end
    endcase
  end

  // Count of neighbors: full rows and full columns give 9, one short 6, both 4
  always_comb begin
    if ((&row_mask) && (&col_mask))      div_sel = DIV_BY_9;
    else if ((&row_mask) || (&col_mask)) div_sel = DIV_BY_6;
    else                                 div_sel = DIV_BY_4;
  end

  // Sum the selected window pixels
  always_comb begin
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_mask[i] && col_mask[j]) begin
          sum = sum + SUM_W'(jq_job_i.win[i][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_sum_q <= sum;
      s1_div_q <= div_sel;
      s1_row_q <= orow;
      s1_col_q <= ocol;
      s1_lob_q <= sel_last;
      s1_lof_q <= lof;
    end
  end

  // Divide: by 6 as halve then multiply by 1/3, by 9 via reciprocal, by 4 as shift
  always_comb begin
    mul_a = s1_sum_q;
    mul_b = RECIP_9;
    if (s1_div_q == DIV_BY_6) begin
      mul_a = {1'b0, s1_sum_q[SUM_W-1:1]};
      mul_b = RECIP_3;
    end
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    case (s1_div_q) inside
      DIV_BY_4: quot = s1_sum_q[PIX_W+1:2];
      DIV_BY_6,
      DIV_BY_9: quot = prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      default:  quot = '0;
    endcase
  end

  assign res_wr.pixel         = quot;
  assign res_wr.row           = s1_row_q;
  assign res_wr.col           = s1_col_q;
  assign res_wr.last_of_burst = s1_lob_q;
  assign res_wr.last_of_frame = s1_lof_q;

  // Result queue
  assign empty_o = (res_cnt_q == '0);
  assign res_pop = pop_i & ~empty_o;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_mem_q[res_wr_ptr_q] <= res_wr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_ptr_q <= '0;
      res_rd_ptr_q <= '0;
      res_cnt_q    <= '0;
    end else begin
      if (s1_valid_q) res_wr_ptr_q <= res_wr_ptr_q + RES_PTR_W'(1);
      if (res_pop)    res_rd_ptr_q <= res_rd_ptr_q + RES_PTR_W'(1);
      res_cnt_q <= res_cnt_q + RES_CNT_W'(s1_valid_q) - RES_CNT_W'(res_pop);
    end
  end

  assign pixel_out_o     = res_mem_q[res_rd_ptr_q].pixel;
  assign out_row_o       = res_mem_q[res_rd_ptr_q].row;
  assign out_col_o       = res_mem_q[res_rd_ptr_q].col;
  assign last_of_burst_o = res_mem_q[res_rd_ptr_q].last_of_burst;
  assign last_of_frame_o = res_mem_q[res_rd_ptr_q].last_of_frame;

endmodule

`default_nettype wire

### sim/box_blur_3x3_edge_normalized_tb.sv
// Testbench for the streaming 3x3 edge-normalized box blur: directed frames,
// saturated geometry and random frames, checked against an in-bench predictor.
// Depends on bbn_pkg and box_blur_3x3_edge_normalized.
`timescale 1ns / 100ps

module box_blur_3x3_edge_normalized_tb;
  import bbn_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 300_000;
  localparam int SETTLE       = 16;
  localparam int IDLE_PCT     = 24;
  localparam int RANDOM_ITEMS = 48;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                push = 1'b0;
  logic                full;
  logic [PIX_W-1:0]    pixel_in_i = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [PIX_W-1:0]    pixel_out_o;
  logic [ROW_W-1:0]    out_row_o;
  logic [COL_W-1:0]    out_col_o;
  logic                last_of_burst_o;
  logic                last_of_frame_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Both sides run without idling while this is set
  logic steady = 1'b0;
  int   mismatch_count = 0;

  // Predictor state: raw registers, line buffers, position and window
  logic [CFG_COLS_W-1:0] frame_cols_reg = CFG_COLS_W'(RESET_COLS);
  logic [CFG_ROWS_W-1:0] frame_rows_reg = CFG_ROWS_W'(RESET_ROWS);
  logic [PIX_W-1:0]      older_row_px [MAX_COLS];
  logic [PIX_W-1:0]      newer_row_px [MAX_COLS];
  logic [PIX_W-1:0]      blur_window [3][3];
  int unsigned           row_at = 0;
  int unsigned           col_at = 0;
  res_t                  blur_expected [$];

  box_blur_3x3_edge_normalized dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .pixel_in_i      (pixel_in_i),
    .empty           (empty),
    .pop             (pop),
    .pixel_out_o     (pixel_out_o),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .last_of_burst_o (last_of_burst_o),
    .last_of_frame_o (last_of_frame_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned cols_eff();
    int unsigned c;
    c = frame_cols_reg;
    if (c < MIN_COLS) c = MIN_COLS;
    if (c > MAX_COLS) c = MAX_COLS;
    return c;
  endfunction

  function automatic int unsigned rows_eff();
    int unsigned r;
    r = frame_rows_reg;
    if (r < MIN_ROWS) r = MIN_ROWS;
    if (r > MAX_ROWS) r = MAX_ROWS;
    return r;
  endfunction

  // Truncated mean of the in-image neighbors around window cell (wr, wc)
  function automatic logic [PIX_W-1:0] neighbor_mean(
      input int wr, input int wc, input int unsigned orow, input int unsigned ocol,
      input int unsigned nrows, input int unsigned ncols);
    int unsigned sum;
    int unsigned cnt;
    int dr;
    int dc;
    sum = 0;
    cnt = 0;
    for (dr = -1; dr <= 1; dr++) begin
      if (dr < 0 && orow == 0) continue;
      if (dr > 0 && orow + 1 >= nrows) continue;
      if (wr + dr < 0 || wr + dr > 2) continue;
      for (dc = -1; dc <= 1; dc++) begin
        if (dc < 0 && ocol == 0) continue;
        if (dc > 0 && ocol + 1 >= ncols) continue;
        if (wc + dc < 0 || wc + dc > 2) continue;
        sum += blur_window[wr + dr][wc + dc];
        cnt++;
      end
    end
    return (cnt != 0) ? PIX_W'(sum / cnt) : '0;
  endfunction

  function automatic res_t blur_result(input logic [PIX_W-1:0] value,
      input int unsigned orow, input int unsigned ocol,
      input int unsigned nrows, input int unsigned ncols);
    res_t res;
    res.pixel         = value;
    res.row           = ROW_W'(orow);
    res.col           = COL_W'(ocol);
    res.last_of_burst = 1'b0;
    res.last_of_frame = (orow + 1 == nrows) && (ocol + 1 == ncols);
    return res;
  endfunction

  // Advance the predictor by one accepted pixel and queue its burst
  task automatic predict_blur(input logic [PIX_W-1:0] px);
    int unsigned ncols;
    int unsigned nrows;
    int unsigned r;
    int unsigned c;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    res_t burst [4];
    int n;
    int k;
    logic last_row;
    logic last_col;
    ncols = cols_eff();
    nrows = rows_eff();
    r = row_at;
    c = col_at;
    n = 0;
    if (r >= nrows) r = 0;
    if (c >= ncols) c = 0;
    last_row = (r + 1 == nrows);
    last_col = (c + 1 == ncols);

    // Shift the window and refresh the line buffers
    top = older_row_px[c];
    mid = newer_row_px[c];
    for (k = 0; k < 3; k++) begin
      blur_window[k][0] = blur_window[k][1];
      blur_window[k][1] = blur_window[k][2];
    end
    blur_window[0][2] = top;
    blur_window[1][2] = mid;
    blur_window[2][2] = px;
    older_row_px[c] = mid;
    newer_row_px[c] = px;

    if (r >= 1) begin
      if (c >= 1) begin
        burst[n] = blur_result(neighbor_mean(1, 1, r - 1, c - 1, nrows, ncols),
                               r - 1, c - 1, nrows, ncols);
        n++;
      end
      if (last_col) begin
        burst[n] = blur_result(neighbor_mean(1, 2, r - 1, c, nrows, ncols),
                               r - 1, c, nrows, ncols);
        n++;
      end
      // Flush the last row along with the one above it
      if (last_row) begin
        if (c >= 1) begin
          burst[n] = blur_result(neighbor_mean(2, 1, r, c - 1, nrows, ncols),
                                 r, c - 1, nrows, ncols);
          n++;
        end
        if (last_col) begin
          burst[n] = blur_result(neighbor_mean(2, 2, r, c, nrows, ncols),
                                 r, c, nrows, ncols);
          n++;
        end
      end
    end
    for (k = 0; k < n; k++) begin
      if (k == n - 1) burst[k].last_of_burst = 1'b1;
      blur_expected.push_back(burst[k]);
    end

    c++;
    if (c >= ncols) begin
      c = 0;
      r++;
      if (r >= nrows) r = 0;
    end
    row_at = r;
    col_at = c;
  endtask

  // ---------------------------------------------------------------- drivers

  // Send one pixel, idling at random first; push stays high on return
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    pixel_in_i <= px;
    do @(posedge clk_i); while (full);
    predict_blur(px);
  endtask

  // Drop push, wait for every expected result, then let the pipeline settle
  task automatic wait_drained();
    push <= 1'b0;
    while (blur_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    // Any register write restarts the frame
    case (idx)
      REG_FRAME_COLS: frame_cols_reg = value[CFG_COLS_W-1:0];
      REG_FRAME_ROWS: frame_rows_reg = value[CFG_ROWS_W-1:0];
      default: ;
    endcase
    row_at = 0;
    col_at = 0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input reg_idx_e idx, input logic [DATA_W-1:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) report_mismatch($sformatf("readback of %s", idx.name()),
                                         want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_frame(input int unsigned cols, input int unsigned rows);
    wait_drained();
    write_reg(REG_FRAME_COLS, DATA_W'(cols));
    write_reg(REG_FRAME_ROWS, DATA_W'(rows));
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_result();
    res_t want;
    string at;
    if (blur_expected.size() == 0) begin
      report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                out_row_o, out_col_o), 0, pixel_out_o);
    end else begin
      want = blur_expected.pop_front();
      at = $sformatf("row %0d col %0d", want.row, want.col);
      if (pixel_out_o !== want.pixel)
        report_mismatch({at, " pixel_out"}, want.pixel, pixel_out_o);
      if (out_row_o !== want.row)
        report_mismatch({at, " out_row"}, want.row, out_row_o);
      if (out_col_o !== want.col)
        report_mismatch({at, " out_col"}, want.col, out_col_o);
      if (last_of_burst_o !== want.last_of_burst)
        report_mismatch({at, " last_of_burst"}, want.last_of_burst, last_of_burst_o);
      if (last_of_frame_o !== want.last_of_frame)
        report_mismatch({at, " last_of_frame"}, want.last_of_frame, last_of_frame_o);
    end
  endtask

  // Take results with random stalls and check each transaction
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result();
      pop <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_register_readback();
    check_reg(REG_FRAME_COLS, DATA_W'(RESET_COLS));
    check_reg(REG_FRAME_ROWS, DATA_W'(RESET_ROWS));
    write_reg(REG_FRAME_COLS, 32'd7);
    write_reg(REG_FRAME_ROWS, 32'd3);
    check_reg(REG_FRAME_COLS, 32'd7);
    check_reg(REG_FRAME_ROWS, 32'd3);
  endtask

  // First row of a frame gives nothing
  task automatic test_first_row_silent();
    set_frame(RESET_COLS, RESET_ROWS);
    send_pixel(8'hA5);
    send_pixel(8'h5A);
    wait_drained();
  endtask

  // Corners only, extremes of the pixel, two frames back to back
  task automatic test_corner_extremes();
    int i;
    set_frame(2, 2);
    for (i = 0; i < 4; i++) send_pixel(8'hFF);
    for (i = 0; i < 4; i++) send_pixel(8'h00);
    wait_drained();
  endtask

  // Corners, edges and one inside pixel
  task automatic test_edges_and_inside();
    logic [PIX_W-1:0] pix [9];
    int i;
    pix = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd127, 8'd64, 8'd200, 8'd3};
    set_frame(3, 3);
    for (i = 0; i < 9; i++) send_pixel(pix[i]);
    wait_drained();
  endtask

  // Out-of-range registers clamp; the largest row count
  task automatic test_saturated_geometry();
    int i;
    set_frame(0, 1);
    for (i = 0; i < 4; i++) send_pixel(PIX_W'($urandom_range(255)));
    set_frame(255, 8191);
    for (i = 0; i < 2; i++) send_pixel(PIX_W'($urandom_range(255)));
    set_frame(2, MAX_ROWS);
    for (i = 0; i < 4; i++) send_pixel(PIX_W'($urandom_range(255)));
    wait_drained();
  endtask

  // Full-width frame with neither side idling
  task automatic test_widest_row();
    int i;
    set_frame(MAX_COLS, 2);
    steady = 1'b1;
    for (i = 0; i < 2 * MAX_COLS; i++) send_pixel(PIX_W'($urandom_range(255)));
    wait_drained();
    steady = 1'b0;
  endtask

  // Mostly whole small frames; some cut short, some wide or clamped
  task automatic test_random_frames();
    int sent;
    int sel;
    int unsigned cols;
    int unsigned rows;
    int count;
    int pause_at;
    int i;
    logic cut;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(99);
      cols = $urandom_range(2, 9);
      rows = $urandom_range(2, 5);
      cut = ($urandom_range(99) < 20);
      if (sel < 8) cols = $urandom_range(0, 1);
      else if (sel < 16) rows = $urandom_range(0, 1);
      else if (sel < 22) cols = $urandom_range(10, 40);
      else if (sel < 26) begin
        cols = $urandom_range(129, 255);
        cut = 1'b1;
      end
      set_frame(cols, rows);

      count = $urandom_range(1, 2) * cols_eff() * rows_eff();
      if (cut) count = $urandom_range(1, (count - 1 < 40) ? count - 1 : 40);
      if (count > RANDOM_ITEMS - sent) count = RANDOM_ITEMS - sent;
      pause_at = ($urandom_range(3) == 0) ? $urandom_range(1, count) : count + 1;
      steady = ($urandom_range(99) < 15);
      for (i = 0; i < count; i++) begin
        // Hold the sender until the block has delivered everything
        if (i == pause_at) wait_drained();
        send_pixel(PIX_W'($urandom_range(255)));
        sent++;
      end
      wait_drained();
      steady = 1'b0;
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < MAX_COLS; i++) begin
      older_row_px[i] = '0;
      newer_row_px[i] = '0;
    end
    for (i = 0; i < 9; i++) blur_window[i / 3][i % 3] = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_readback();
    test_first_row_silent();
    test_corner_extremes();
    test_edges_and_inside();
    test_saturated_geometry();
    test_widest_row();
    test_random_frames();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### box_blur_3x3_edge_normalized.f
design/bbn_pkg.sv
design/bbn_regs.sv
design/bbn_front.sv
design/bbn_job_q.sv
design/bbn_back.sv
design/box_blur_3x3_edge_normalized.sv
sim/box_blur_3x3_edge_normalized_tb.sv
